// ===== rtl/lsst_pkg.sv =====
// Shared types, constants and helpers for the leap second sorted table.
// Used by lsst_cell and leap_second_sorted_table_unit; depends on nothing.
package lsst_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int TIME_BITS   = 40;
   localparam int TOTAL_BITS  = 16;
   localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_SET   = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DUP  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // Update broadcast from the top level to every cell.
   typedef struct packed {
      logic                          shift_en;
      logic                          relative;
      logic signed [TOTAL_BITS-1:0]  amount;
      logic [TIME_BITS-1:0]          new_time;
      logic signed [TOTAL_BITS-1:0]  new_total;
   } cell_ctrl_type;

   // Sum of two totals clamped to the signed total range.
   function automatic logic signed [TOTAL_BITS-1:0] sat_add(
      input logic signed [TOTAL_BITS-1:0] a,
      input logic signed [TOTAL_BITS-1:0] b
   );
      logic signed [TOTAL_BITS:0] sum;
      sum = {a[TOTAL_BITS-1], a} + {b[TOTAL_BITS-1], b};
      if (sum[TOTAL_BITS] != sum[TOTAL_BITS-1]) begin
         sat_add = sum[TOTAL_BITS] ? {1'b1, {(TOTAL_BITS-1){1'b0}}}
                                   : {1'b0, {(TOTAL_BITS-1){1'b1}}};
      end else begin
         sat_add = sum[TOTAL_BITS-1:0];
      end
   endfunction

endpackage

// ===== rtl/leap_second_sorted_table_unit.sv =====
// Top level of the leap second sorted table: request register, cell row, result register.
// Depends on lsst_pkg and lsst_cell.
//
// Usage:
//   req_* carries one item: operation (add, set, query, clear), event_time
//   and amount. rsp_* returns exactly one result item per request: status,
//   offset, interval_start, interval_end and entry_count.
//   Every table entry is a cell; all cells compare their time against the
//   request time in the cycle the item is accepted; then, once the result
//   register can take it, the row either shifts right by one from the insert
//   point or is left alone, and the result register is loaded.
//   rsp_valid rises once the item completes and the result register is loaded.
//   A new item is accepted only after the item in flight completes. The
//   compare-then-update pass over the cell row sets this; the next
//   item is compared against the updated row.
//   Stall: while rsp_stall holds a result, the item in flight waits before
//   its update, and req_stall stays high until it can complete.
//   Reset: synchronous, active high; empties the table (entry count 0), drops
//   any item in flight and holds req_stall high. Entry storage is not cleared.
module leap_second_sorted_table_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_operation,
   input  logic [lsst_pkg::TIME_BITS-1:0]         req_event_time,
   input  logic signed [lsst_pkg::TOTAL_BITS-1:0] req_amount,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_status,
   output logic signed [lsst_pkg::TOTAL_BITS-1:0] rsp_offset,
   output logic [lsst_pkg::TIME_BITS-1:0]         rsp_interval_start,
   output logic [lsst_pkg::TIME_BITS-1:0]         rsp_interval_end,
   output logic [lsst_pkg::COUNT_BITS-1:0]        rsp_entry_count
);

   localparam int DEPTH = lsst_pkg::TABLE_DEPTH;
   localparam int TB    = lsst_pkg::TIME_BITS;
   localparam int SB    = lsst_pkg::TOTAL_BITS;
   localparam int CB    = lsst_pkg::COUNT_BITS;

   // Request stage
   logic                     busy_ff, busy_in;
   lsst_pkg::op_type         op_ff;
   logic [TB-1:0]            time_ff;
   logic signed [SB-1:0]     amount_ff;
   logic [CB-1:0]            fill_ff, fill_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   lsst_pkg::status_type     status_ff, status_in;
   logic signed [SB-1:0]     offset_ff, offset_in;
   logic [TB-1:0]            start_ff, start_in;
   logic [TB-1:0]            end_ff, end_in;
   logic [CB-1:0]            count_ff, count_in;

   // Cell row
   logic [TB-1:0]            cell_time   [DEPTH];
   logic signed [SB-1:0]     cell_total  [DEPTH];
   logic [DEPTH-1:0]         cell_before;
   logic [DEPTH-1:0]         cell_ge;
   logic [DEPTH-1:0]         cell_eq;
   logic [DEPTH-1:0]         prev_before;
   lsst_pkg::cell_ctrl_type  ctrl;

   logic                     accept;
   logic                     done;
   logic                     is_insert;
   logic                     dup;
   logic                     full;
   logic                     lb_found;
   logic                     fnb_found;
   logic signed [SB-1:0]     lb_total;
   logic [TB-1:0]            lb_time;
   logic [TB-1:0]            fnb_time;

   assign req_stall = busy_ff || reset;
   assign accept    = req_valid && !req_stall;
   // Complete the item once the result register is free or being emptied.
   assign done      = busy_ff && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= lsst_pkg::op_type'(req_operation);
         time_ff   <= req_event_time;
         amount_ff <= req_amount;
      end
   end

   // Cell 0 sees an imaginary earlier entry that is always before the key.
   assign prev_before = {cell_before[DEPTH-2:0], 1'b1};

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [TB-1:0]        nb_time;
      logic signed [SB-1:0] nb_total;
      if (i == 0) begin : g_first
         assign nb_time  = '0;
         assign nb_total = '0;
      end else begin : g_rest
         assign nb_time  = cell_time[i-1];
         assign nb_total = cell_total[i-1];
      end
      lsst_cell u_cell (
         .clock       (clock),
         .load_flags  (accept),
         .valid       (fill_ff > CB'(i)),
         .key_time    (req_event_time),
         .ctrl        (ctrl),
         .prev_before (prev_before[i]),
         .prev_time   (nb_time),
         .prev_total  (nb_total),
         .time_out    (cell_time[i]),
         .total_out   (cell_total[i]),
         .before_out  (cell_before[i]),
         .ge_out      (cell_ge[i]),
         .eq_out      (cell_eq[i])
      );
   end

   // Pick the last entry before the key and the first entry not before it.
   always_comb begin
      lb_found  = 1'b0;
      fnb_found = 1'b0;
      lb_total  = '0;
      lb_time   = '0;
      fnb_time  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_before[i] && ((i == DEPTH - 1) || !cell_before[(i + 1) % DEPTH])) begin
            lb_found = 1'b1;
            lb_total = lb_total | cell_total[i];
            lb_time  = lb_time | cell_time[i];
         end
         if (cell_ge[i] && prev_before[i]) begin
            fnb_found = 1'b1;
            fnb_time  = fnb_time | cell_time[i];
         end
      end
   end

   assign dup       = |cell_eq;
   assign full      = (fill_ff == CB'(DEPTH));
   assign is_insert = (op_ff == lsst_pkg::OP_ADD) || (op_ff == lsst_pkg::OP_SET);

   always_comb begin
      ctrl.shift_en  = done && is_insert && !dup && !full;
      ctrl.relative  = (op_ff == lsst_pkg::OP_ADD);
      ctrl.amount    = amount_ff;
      ctrl.new_time  = time_ff;
      ctrl.new_total = ctrl.relative
                       ? lsst_pkg::sat_add(lb_found ? lb_total : SB'(0), amount_ff)
                       : amount_ff;
   end

   // Result fields and next fill level.
   always_comb begin
      status_in = lsst_pkg::ST_OK;
      offset_in = '0;
      start_in  = '0;
      end_in    = '0;
      fill_in   = fill_ff;
      case (op_ff)
         lsst_pkg::OP_ADD, lsst_pkg::OP_SET: begin
            if (dup) begin
               status_in = lsst_pkg::ST_DUP;
            end else if (full) begin
               status_in = lsst_pkg::ST_FULL;
            end else begin
               fill_in = fill_ff + CB'(1);
            end
         end
         lsst_pkg::OP_QUERY: begin
            offset_in = lb_found ? lb_total : SB'(0);
            start_in  = lb_found ? lb_time : TB'(0);
            end_in    = fnb_found ? fnb_time : {TB{1'b1}};
         end
         lsst_pkg::OP_CLEAR: begin
            fill_in = '0;
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
      count_in = fill_in;
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (done) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         status_ff <= status_in;
         offset_ff <= offset_in;
         start_ff  <= start_in;
         end_ff    <= end_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_offset         = offset_ff;
   assign rsp_interval_start = start_ff;
   assign rsp_interval_end   = end_ff;
   assign rsp_entry_count    = count_ff;

endmodule

// ===== rtl/lsst_cell.sv =====
// One entry of the sorted leap second table: event time, total and compare flags.
// Depends on lsst_pkg.
module lsst_cell (
   input  logic                                  clock,
   input  logic                                  load_flags,
   input  logic                                  valid,
   input  logic [lsst_pkg::TIME_BITS-1:0]        key_time,
   input  lsst_pkg::cell_ctrl_type               ctrl,
   input  logic                                  prev_before,
   input  logic [lsst_pkg::TIME_BITS-1:0]        prev_time,
   input  logic signed [lsst_pkg::TOTAL_BITS-1:0] prev_total,
   output logic [lsst_pkg::TIME_BITS-1:0]        time_out,
   output logic signed [lsst_pkg::TOTAL_BITS-1:0] total_out,
   output logic                                  before_out,
   output logic                                  ge_out,
   output logic                                  eq_out
);

   logic [lsst_pkg::TIME_BITS-1:0]         time_ff;
   logic signed [lsst_pkg::TOTAL_BITS-1:0] total_ff;
   logic                                   before_ff;
   logic                                   ge_ff;
   logic                                   eq_ff;

   // Compare flags are taken when an item is accepted.
   always_ff @(posedge clock) begin
      if (load_flags) begin
         before_ff <= valid && (time_ff < key_time);
         ge_ff     <= valid && (time_ff >= key_time);
         eq_ff     <= valid && (time_ff == key_time);
      end
   end

   // Hold entries before the insert point, take the new entry at it, shift the rest.
   always_ff @(posedge clock) begin
      if (ctrl.shift_en && !before_ff) begin
         if (prev_before) begin
            time_ff  <= ctrl.new_time;
            total_ff <= ctrl.new_total;
         end else begin
            time_ff  <= prev_time;
            total_ff <= ctrl.relative ? lsst_pkg::sat_add(prev_total, ctrl.amount)
                                      : prev_total;
         end
      end
   end

   assign time_out   = time_ff;
   assign total_out  = total_ff;
   assign before_out = before_ff;
   assign ge_out     = ge_ff;
   assign eq_out     = eq_ff;

endmodule
